FILE: sv/lfucl_pkg.sv
// ----------------------------------------------------------------------------
// lfucl_pkg
// Shared types and constants for the LFU cache with LRU tie break.
// ----------------------------------------------------------------------------
package lfucl_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] store_value;
  } in_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } out_rsp_t;

endpackage

FILE: sv/lfucl_ram.sv
// ----------------------------------------------------------------------------
// lfucl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfucl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lfucl_scan.sv
// ----------------------------------------------------------------------------
// lfucl_scan
// Shared compare unit: one entry per cycle while sample is high, for key match, victim and free slot.
// ----------------------------------------------------------------------------
module lfucl_scan #(
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             sample,
  input  logic [IDX_W-1:0]                 s_idx,
  input  logic                             s_valid,
  input  logic [lfucl_pkg::DATA_W-1:0]     s_key,
  input  logic [lfucl_pkg::DATA_W-1:0]     s_val,
  input  logic [COUNT_BITS-1:0]            s_count,
  input  logic [IDX_W-1:0]                 s_rank,
  input  logic [lfucl_pkg::DATA_W-1:0]     key,
  output logic                             hit_found,
  output logic [IDX_W-1:0]                 hit_idx,
  output logic [lfucl_pkg::DATA_W-1:0]     hit_val,
  output logic [COUNT_BITS-1:0]            hit_cnt,
  output logic [IDX_W-1:0]                 hit_rank,
  output logic [IDX_W-1:0]                 vic_idx,
  output logic [IDX_W-1:0]                 vic_rank,
  output logic [IDX_W-1:0]                 free_idx
);

  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  logic [lfucl_pkg::DATA_W-1:0] hit_val_r;
  logic [COUNT_BITS-1:0]        hit_cnt_r;
  logic [IDX_W-1:0]             hit_rank_r;
  logic                         vic_r;
  logic [IDX_W-1:0]             vic_idx_r;
  logic [COUNT_BITS-1:0]        vic_cnt_r;
  logic [IDX_W-1:0]             vic_rank_r;
  logic                         free_r;
  logic [IDX_W-1:0]             free_idx_r;

  logic key_eq;
  logic vic_better;
  logic free_take;

  assign key_eq     = s_valid && (s_key == key) && !hit_r;
  assign vic_better = s_valid && (!vic_r || (s_count < vic_cnt_r) ||
                      ((s_count == vic_cnt_r) && (s_rank > vic_rank_r)));
  assign free_take  = !s_valid && !free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      vic_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (clear) begin
      hit_r  <= 1'b0;
      vic_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (sample) begin
      if (key_eq) begin
        hit_r <= 1'b1;
      end
      if (vic_better) begin
        vic_r <= 1'b1;
      end
      if (free_take) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample && key_eq) begin
      hit_idx_r  <= s_idx;
      hit_val_r  <= s_val;
      hit_cnt_r  <= s_count;
      hit_rank_r <= s_rank;
    end
    if (sample && vic_better) begin
      vic_idx_r  <= s_idx;
      vic_cnt_r  <= s_count;
      vic_rank_r <= s_rank;
    end
    if (sample && free_take) begin
      free_idx_r <= s_idx;
    end
  end

  assign hit_found = hit_r;
  assign hit_idx   = hit_idx_r;
  assign hit_val   = hit_val_r;
  assign hit_cnt   = hit_cnt_r;
  assign hit_rank  = hit_rank_r;
  assign vic_idx   = vic_idx_r;
  assign vic_rank  = vic_rank_r;
  assign free_idx  = free_idx_r;

endmodule

FILE: sv/lfu_cache_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// Key/value cache, least frequently used eviction, least recent among ties.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as in_req (cmd, lookup_key, store_value).
// A get returns one response on out_valid/out_ready as out_rsp (hit, read_value,
// -1 on a miss); a put returns nothing. cfg_we/cfg_data set the capacity at any
// idle moment, values above ENTRIES act as ENTRIES, zero ignores every put.
// Each request is handled alone: a scan of all ENTRIES slots through the shared
// compare unit (one RAM read a cycle), a decide state, and, unless it is a get
// miss or an ignored put, a rank sweep that rewrites every slot's count/rank
// word (one RAM write a cycle). in_ready is low from acceptance until the block
// is idle again; for a get it rises together with out_valid.
// Responses sit in an output register; a new request is taken while one waits,
// and only a get that finishes while the register is still full holds there
// until out_ready frees it. Reset empties the cache, clears the output and
// sets the capacity to 16; key, value and count/rank RAMs are not cleared.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lfucl_pkg::in_req_t            in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lfucl_pkg::out_rsp_t           out_rsp,
  input  logic                          cfg_we,
  input  logic [lfucl_pkg::CAP_W-1:0]   cfg_data
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CTR_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CTR_W > lfucl_pkg::CAP_W) ? CTR_W : lfucl_pkg::CAP_W;
  localparam int META_W = COUNT_BITS + IDX_W;
  localparam int DW     = lfucl_pkg::DATA_W;

  lfucl_pkg::state_t   state_r, state_nxt;
  lfucl_pkg::in_req_t  req_r, req_nxt;
  lfucl_pkg::out_rsp_t rsp_r, rsp_nxt;
  lfucl_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CTR_W-1:0]           idx_r, idx_nxt;
  logic [ENTRIES-1:0]         valid_r, valid_nxt;
  logic [CTR_W-1:0]           total_r, total_nxt;
  logic [lfucl_pkg::CAP_W-1:0] cap_r;
  logic [IDX_W-1:0]           slot_r, slot_nxt;
  logic [CTR_W-1:0]           thr_r, thr_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt;

  logic [CTR_W-1:0]      prev_ctr;
  logic [IDX_W-1:0]      prev_idx;
  logic [IDX_W-1:0]      rd_addr;
  logic                  last;
  logic                  scan_clear;
  logic                  scan_sample;

  logic [DW-1:0]         key_q;
  logic [DW-1:0]         val_q;
  logic [META_W-1:0]     meta_q;
  logic [COUNT_BITS-1:0] q_cnt;
  logic [IDX_W-1:0]      q_rank;

  logic                  kv_we;
  logic                  val_we;
  logic [IDX_W-1:0]      kv_addr;
  logic                  meta_we;
  logic [META_W-1:0]     meta_wdata;

  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [DW-1:0]         hit_val;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [IDX_W-1:0]      hit_rank;
  logic [IDX_W-1:0]      vic_idx;
  logic [IDX_W-1:0]      vic_rank;
  logic [IDX_W-1:0]      free_idx;

  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  cap_zero;
  logic                  full;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign prev_ctr = idx_r - CTR_W'(1);
  assign prev_idx = prev_ctr[IDX_W-1:0];
  assign rd_addr  = idx_r[IDX_W-1:0];
  assign last     = (idx_r == CTR_W'(ENTRIES));
  assign q_cnt    = meta_q[META_W-1 -: COUNT_BITS];
  assign q_rank   = meta_q[IDX_W-1:0];

  assign cap_ext  = CMP_W'(cap_r);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign cap_zero = (cap_r == '0);
  assign full     = (CMP_W'(total_r) >= cap_eff);
  assign cnt_inc  = (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_BITS'(1);

  assign scan_clear  = (state_r == lfucl_pkg::ST_IDLE) && in_valid;
  assign scan_sample = (state_r == lfucl_pkg::ST_SCAN) && (idx_r != '0);

  lfucl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_addr),
    .wdata (req_r.lookup_key),
    .raddr (rd_addr),
    .rdata (key_q)
  );

  lfucl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (kv_addr),
    .wdata (req_r.store_value),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  lfucl_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (prev_idx),
    .wdata (meta_wdata),
    .raddr (rd_addr),
    .rdata (meta_q)
  );

  lfucl_scan #(.IDX_W(IDX_W), .COUNT_BITS(COUNT_BITS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (scan_clear),
    .sample    (scan_sample),
    .s_idx     (prev_idx),
    .s_valid   (valid_r[prev_idx]),
    .s_key     (key_q),
    .s_val     (val_q),
    .s_count   (q_cnt),
    .s_rank    (q_rank),
    .key       (req_r.lookup_key),
    .hit_found (hit_found),
    .hit_idx   (hit_idx),
    .hit_val   (hit_val),
    .hit_cnt   (hit_cnt),
    .hit_rank  (hit_rank),
    .vic_idx   (vic_idx),
    .vic_rank  (vic_rank),
    .free_idx  (free_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfucl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      total_r     <= '0;
      cap_r       <= lfucl_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rsp_r     <= rsp_nxt;
    out_rsp_r <= out_rsp_nxt;
    idx_r     <= idx_nxt;
    slot_r    <= slot_nxt;
    thr_r     <= thr_nxt;
    cnt_r     <= cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    slot_nxt      = slot_r;
    thr_nxt       = thr_r;
    cnt_nxt       = cnt_r;
    kv_we         = 1'b0;
    val_we        = 1'b0;
    kv_addr       = hit_idx;
    meta_we       = 1'b0;
    meta_wdata    = meta_q;

    unique case (state_r)
      lfucl_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          state_nxt = lfucl_pkg::ST_SCAN;
        end
      end

      lfucl_pkg::ST_SCAN: begin
        idx_nxt = idx_r + CTR_W'(1);
        if (last) begin
          state_nxt = lfucl_pkg::ST_DECIDE;
        end
      end

      lfucl_pkg::ST_DECIDE: begin
        idx_nxt = '0;
        if (req_r.cmd == lfucl_pkg::CMD_GET) begin
          rsp_nxt.hit        = hit_found;
          rsp_nxt.read_value = hit_found ? hit_val : lfucl_pkg::MISS_VALUE;
          slot_nxt           = hit_idx;
          thr_nxt            = CTR_W'(hit_rank);
          cnt_nxt            = cnt_inc;
          state_nxt          = hit_found ? lfucl_pkg::ST_SWEEP : lfucl_pkg::ST_RESP;
        end else if (cap_zero) begin
          state_nxt = lfucl_pkg::ST_IDLE;
        end else if (hit_found) begin
          val_we    = 1'b1;
          kv_addr   = hit_idx;
          slot_nxt  = hit_idx;
          thr_nxt   = CTR_W'(hit_rank);
          cnt_nxt   = cnt_inc;
          state_nxt = lfucl_pkg::ST_SWEEP;
        end else if (full) begin
          kv_we     = 1'b1;
          val_we    = 1'b1;
          kv_addr   = vic_idx;
          slot_nxt  = vic_idx;
          thr_nxt   = CTR_W'(vic_rank);
          cnt_nxt   = COUNT_BITS'(1);
          state_nxt = lfucl_pkg::ST_SWEEP;
        end else begin
          kv_we              = 1'b1;
          val_we             = 1'b1;
          kv_addr            = free_idx;
          slot_nxt           = free_idx;
          thr_nxt            = total_r;
          cnt_nxt            = COUNT_BITS'(1);
          valid_nxt[free_idx] = 1'b1;
          total_nxt          = total_r + CTR_W'(1);
          state_nxt          = lfucl_pkg::ST_SWEEP;
        end
      end

      lfucl_pkg::ST_SWEEP: begin
        idx_nxt = idx_r + CTR_W'(1);
        meta_we = (idx_r != '0);
        // touched slot goes to rank 0, more recent valid entries age by one
        if (prev_idx == slot_r) begin
          meta_wdata = {cnt_r, IDX_W'(0)};
        end else if (valid_r[prev_idx] && (CTR_W'(q_rank) < thr_r)) begin
          meta_wdata = {q_cnt, q_rank + IDX_W'(1)};
        end
        if (last) begin
          state_nxt = (req_r.cmd == lfucl_pkg::CMD_GET) ? lfucl_pkg::ST_RESP
                                                        : lfucl_pkg::ST_IDLE;
        end
      end

      lfucl_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = rsp_r;
          state_nxt     = lfucl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lfucl_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == lfucl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sv/lfucl_chk.sv
// ----------------------------------------------------------------------------
// lfucl_chk
// Port-level checks for the LFU cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfucl_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lfucl_pkg::out_rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.hit |-> out_rsp.read_value == lfucl_pkg::MISS_VALUE)
    else $error("miss response without all-ones value");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after taking a request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left response pending or block busy");

endmodule

bind lfu_cache_lru_tiebreak lfucl_chk u_lfucl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

FILE: tb/lfu_cache_lru_tiebreak_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_tb
// Self-checking bench for the LFU cache with LRU tie break. A short table of
// directed requests (extreme keys and values, updates, eviction at a lowered
// capacity, ignored puts at capacity zero, capacity above the slot count) is
// followed by random traffic over a small key pool with hot keys, run under
// several capacities. Every get response is checked against the table row or a
// cycle-free model of the cache in the bench; both handshakes idle at random and
// the response side holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_tb;

  localparam int          CAP_W      = lfucl_pkg::CAP_W;
  localparam logic        CMD_GET    = lfucl_pkg::CMD_GET;
  localparam logic        CMD_PUT    = lfucl_pkg::CMD_PUT;
  localparam logic [31:0] MISS_VALUE = lfucl_pkg::MISS_VALUE;

  localparam int ENTRIES     = 16;
  // narrow counters so saturation shows up within the run
  localparam int COUNT_W     = 4;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int DRAIN       = 2 * ENTRIES + 8;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 400000;
  localparam int POOL_N      = 24;
  localparam int DIR_N       = 25;
  localparam int PHASE_N     = 6;

  localparam int PHASE_CAP [PHASE_N] = '{31, 4, 1, 0, 2, 16};
  localparam int PHASE_LEN [PHASE_N] = '{300, 200, 120, 60, 140, 230};

  typedef struct packed {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic             cmd;
    logic [31:0]      key;
    logic [31:0]      val;
    logic             typed;
    logic             exp_hit;
    logic [31:0]      exp_val;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lfucl_pkg::in_req_t  in_req;
  logic                out_valid;
  logic                out_ready;
  lfucl_pkg::out_rsp_t out_rsp;
  logic                cfg_we;
  logic [CAP_W-1:0]    cfg_data;

  // cache image
  logic             ent_valid [ENTRIES];
  logic [31:0]      ent_key   [ENTRIES];
  logic [31:0]      ent_val   [ENTRIES];
  int unsigned      ent_count [ENTRIES];
  int unsigned      ent_rank  [ENTRIES];
  int unsigned      fill;
  logic [CAP_W-1:0] cap_reg;

  lfucl_pkg::out_rsp_t rsp_expect_q [$];
  logic [31:0] key_pool [POOL_N];
  dir_row_t    dir_rows [DIR_N];
  int unsigned errors;
  int unsigned rsp_seen;
  int unsigned cycle_count;
  bit          send_burst;
  bit          recv_burst;
  bit          held_off;

  lfu_cache_lru_tiebreak #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void lfu_touch(int s);
    int unsigned r;
    r = ent_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && i != s && ent_rank[i] < r) ent_rank[i]++;
    ent_rank[s] = 0;
  endfunction

  function automatic void lfu_bump(int s);
    if (ent_count[s] < COUNT_MAX) ent_count[s]++;
    lfu_touch(s);
  endfunction

  function automatic int lfu_find(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int lfu_victim();
    int v;
    v = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_valid[i] && (v < 0 || ent_count[i] < ent_count[v] ||
          (ent_count[i] == ent_count[v] && ent_rank[i] > ent_rank[v]))) v = i;
    end
    return v;
  endfunction

  // returns 1 when the request produces a response
  function automatic bit lfu_predict(input lfucl_pkg::in_req_t r,
                                     output lfucl_pkg::out_rsp_t rsp);
    int          s;
    int          v;
    int unsigned eff;
    int unsigned vr;
    eff = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    s = lfu_find(r.lookup_key);
    rsp = '0;
    if (r.cmd == CMD_GET) begin
      if (s < 0) begin
        rsp.hit = 1'b0;
        rsp.read_value = MISS_VALUE;
      end else begin
        lfu_bump(s);
        rsp.hit = 1'b1;
        rsp.read_value = ent_val[s];
      end
      return 1'b1;
    end
    if (eff == 0) return 1'b0;
    if (s >= 0) begin
      ent_val[s] = r.store_value;
      lfu_bump(s);
      return 1'b0;
    end
    if (fill >= eff) begin
      v = lfu_victim();
      if (v < 0) return 1'b0;
      vr = ent_rank[v];
      for (int i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && ent_rank[i] > vr) ent_rank[i]--;
      ent_valid[v] = 1'b0;
      fill--;
      s = v;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (!ent_valid[i] && s < 0) s = i;
      if (s < 0) return 1'b0;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i]) ent_rank[i]++;
    ent_valid[s] = 1'b1;
    ent_key[s]   = r.lookup_key;
    ent_val[s]   = r.store_value;
    ent_count[s] = 1;
    ent_rank[s]  = 0;
    fill++;
    return 1'b0;
  endfunction

  task automatic send_req(input lfucl_pkg::in_req_t r, input bit typed,
                          input lfucl_pkg::out_rsp_t typed_rsp);
    int                  gap;
    bit                  has_rsp;
    lfucl_pkg::out_rsp_t rsp;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    has_rsp = lfu_predict(r, rsp);
    if (has_rsp) rsp_expect_q.push_back(typed ? typed_rsp : rsp);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk);
    // a put leaves no response, so give the block time to finish it
    repeat (DRAIN) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg = v;
  endtask

  initial begin : rsp_side
    int                  stall;
    lfucl_pkg::out_rsp_t want;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 10);
      if (!held_off && rsp_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      rsp_seen++;
      if (rsp_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: hit=%0b value=%08h", out_rsp.hit,
                   out_rsp.read_value);
      end else begin
        want = rsp_expect_q.pop_front();
        if (out_rsp.hit !== want.hit || out_rsp.read_value !== want.read_value) begin
          errors++;
          if (errors <= 10)
            $display("response mismatch: expected hit=%0b value=%08h, got hit=%0b value=%08h",
                     want.hit, want.read_value, out_rsp.hit, out_rsp.read_value);
        end
      end
    end
  end

  initial begin : req_side
    int                  eff;
    int                  span;
    int                  pick;
    lfucl_pkg::in_req_t  req;
    lfucl_pkg::out_rsp_t typed;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = lfucl_pkg::CAP_RESET;
    cap_reg   = lfucl_pkg::CAP_RESET;
    fill      = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_val[i]   = '0;
      ent_count[i] = 0;
      ent_rank[i]  = 0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    dir_rows = '{
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      '{1'b0, 5'd0,  CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{1'b0, 5'd0,  CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{1'b0, 5'd0,  CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      // capacity below the fill, next insert evicts the older low count
      '{1'b1, 5'd2,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      // zero capacity ignores puts, present key included
      '{1'b1, 5'd0,  CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0009, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
      // capacity above the slot count
      '{1'b1, 5'd31, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, 1'b0, 32'h0},
      '{1'b0, 5'd0,  CMD_GET, 32'h0000_0009, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0009}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].is_cfg) begin
        set_capacity(dir_rows[i].cap);
      end else begin
        req.cmd          = dir_rows[i].cmd;
        req.lookup_key   = dir_rows[i].key;
        req.store_value  = dir_rows[i].val;
        typed.hit        = dir_rows[i].exp_hit;
        typed.read_value = dir_rows[i].exp_val;
        send_req(req, dir_rows[i].typed, typed);
      end
    end

    for (int p = 0; p < PHASE_N; p++) begin
      set_capacity(CAP_W'(PHASE_CAP[p]));
      eff  = (PHASE_CAP[p] > ENTRIES) ? ENTRIES : PHASE_CAP[p];
      span = (2 * eff + 6 > POOL_N) ? POOL_N : 2 * eff + 6;
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        pick            = $urandom_range(0, 99);
        req.cmd         = 1'($urandom_range(0, 1));
        req.store_value = $urandom;
        if (pick < 8)
          req.lookup_key = $urandom;
        else if (pick < 40)
          req.lookup_key = key_pool[$urandom_range(0, 3)];
        else
          req.lookup_key = key_pool[$urandom_range(0, span - 1)];
        send_req(req, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && rsp_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
